@@ src/efcs_pkg.sv @@
// ----------------------------------------------------------------------------
// efcs_pkg
// Types, constants and codes shared by the frame class statistics block.
// ----------------------------------------------------------------------------
package efcs_pkg;

  // Defaults for the top level parameters.
  localparam int MAX_FRAME_DEF     = 1518;
  localparam int COUNTER_WIDTH_DEF = 32;

  // Fixed widths.
  localparam int POS_W       = 11;
  localparam int STAT_W      = 48;
  localparam int STAT_ID_W   = 4;
  localparam int OUT_TDATA_W = 56;
  localparam int IN_TDATA_W  = 8;

  // Saturating event counters: frames, then the nine frame classes.
  localparam int NUM_COUNTERS = 10;
  localparam int CNT_IDX_W    = $clog2(NUM_COUNTERS);

  // Frame record queue between the parser and the statistics engine.
  localparam int QUEUE_DEPTH = 4;

  // Byte positions within the frame.
  localparam logic [POS_W-1:0] POS_ETYPE_HI = 11'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO = 11'd13;
  localparam logic [POS_W-1:0] POS_IP_IHL   = 11'd14;
  localparam logic [POS_W-1:0] POS_OPC_HI   = 11'd20;
  localparam logic [POS_W-1:0] POS_OPC_LO   = 11'd21;
  localparam logic [POS_W-1:0] POS_IP_PROTO = 11'd23;
  localparam logic [POS_W-1:0] ETH_HDR_LEN  = 11'd14;
  localparam logic [POS_W-1:0] TCP_FLAGS_OFS = 11'd13;
  localparam logic [POS_W-1:0] POS_LIMIT    = 11'd2047;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ARP_OP_REQ = 16'd1;
  localparam logic [15:0] ARP_OP_REP = 16'd2;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [7:0]  ICMP_ECHO_REQ = 8'd8;
  localparam logic [7:0]  ICMP_ECHO_REP = 8'd0;
  localparam logic [3:0]  IHL_MIN    = 4'd5;
  localparam int          TCP_SYN_BIT = 1;

  typedef enum logic [STAT_ID_W-1:0] {
    STAT_FRAMES  = 4'd0,
    STAT_MIN     = 4'd1,
    STAT_MAX     = 4'd2,
    STAT_BYTES   = 4'd3,
    STAT_ARP     = 4'd4,
    STAT_ARP_REQ = 4'd5,
    STAT_ARP_REP = 4'd6,
    STAT_ICMP    = 4'd7,
    STAT_ECHO    = 4'd8,
    STAT_REPLY   = 4'd9,
    STAT_UDP     = 4'd10,
    STAT_TCP     = 4'd11,
    STAT_SYN     = 4'd12
  } stat_id_t;

  // Classes found in one frame, in counter order after the frame counter.
  typedef struct packed {
    logic syn;
    logic tcp;
    logic udp;
    logic reply;
    logic echo;
    logic icmp;
    logic arp_rep;
    logic arp_req;
    logic arp;
  } frame_class_t;

  typedef struct packed {
    logic [POS_W-1:0] size;
    frame_class_t     cls;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

endpackage

@@ src/ethernet_frame_class_statistics.sv @@
// ----------------------------------------------------------------------------
// ethernet_frame_class_statistics
// Per-frame classifier (ARP, ICMP echo, UDP, TCP SYN) with saturating
// statistics counters, streamed out after every frame.
// ----------------------------------------------------------------------------
// Frame bytes are taken at one beat per cycle while s_tready is high. On the
// last beat of a frame the parser queues a record of the size and the classes
// found; the statistics engine takes one record, updates its counters and then
// sends thirteen beats, one per cycle while m_tready is high. A four-entry
// record queue lets frames of 14 bytes or more stream at full byte rate; a run
// of shorter frames holds s_tready low once the queue is full. The first byte
// after reset can be accepted in the first cycle.
module ethernet_frame_class_statistics #(
  parameter int MAX_FRAME     = efcs_pkg::MAX_FRAME_DEF,
  parameter int COUNTER_WIDTH = efcs_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [efcs_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] frame_byte
  input  logic                             s_tlast,   // end_of_frame
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [efcs_pkg::OUT_TDATA_W-1:0] m_tdata,   // [3:0] stat_id, [51:4] stat_value
  output logic                             m_tlast    // last_stat
);

  efcs_pkg::frame_rec_t    push_rec, pop_rec;
  efcs_pkg::queue_status_t qstat;
  logic push, pop, beat;

  assign s_tready = !qstat.full;
  assign beat     = s_tvalid && s_tready;

  efcs_parser #(
    .MAX_FRAME(MAX_FRAME)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .beat        (beat),
    .frame_byte  (s_tdata),
    .end_of_frame(s_tlast),
    .push        (push),
    .rec         (push_rec)
  );

  efcs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_rec(push_rec),
    .pop     (pop),
    .pop_rec (pop_rec),
    .status  (qstat)
  );

  efcs_stats #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_stats (
    .clk     (clk),
    .rst     (rst),
    .rec     (pop_rec),
    .qstat   (qstat),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

@@ src/efcs_parser.sv @@
// ----------------------------------------------------------------------------
// efcs_parser
// Front part: parses each frame byte by byte and, on the last beat, hands a
// record of the frame size and its classes to the queue.
// ----------------------------------------------------------------------------
module efcs_parser #(
  parameter int MAX_FRAME = efcs_pkg::MAX_FRAME_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 beat,        // byte accepted this cycle
  input  logic [7:0]           frame_byte,
  input  logic                 end_of_frame,
  output logic                 push,
  output efcs_pkg::frame_rec_t rec
);

  localparam logic [efcs_pkg::POS_W-1:0] MaxFrame = efcs_pkg::POS_W'(MAX_FRAME);

  logic [efcs_pkg::POS_W-1:0] pos, pos_next;
  logic [15:0] etype, etype_next;
  logic [3:0]  hdr_words, hdr_words_next;
  logic [7:0]  proto, proto_next;
  logic [15:0] opcode, opcode_next;
  logic typed, typed_next;
  logic proto_seen, proto_seen_next;
  logic opc_seen, opc_seen_next;
  logic echo, echo_next;
  logic reply, reply_next;
  logic syn, syn_next;

  logic in_range, parse, ipv4, arp;
  logic [efcs_pkg::POS_W-1:0] tp;
  logic ip_ok, arp_ok;

  assign in_range = pos < MaxFrame;
  assign parse    = in_range && typed && (pos >= efcs_pkg::ETH_HDR_LEN);
  assign ipv4     = etype == efcs_pkg::ETYPE_IPV4;
  assign arp      = etype == efcs_pkg::ETYPE_ARP;
  assign tp       = efcs_pkg::ETH_HDR_LEN + {5'b0, hdr_words, 2'b00};

  always_comb begin
    etype_next      = etype;
    hdr_words_next  = hdr_words;
    proto_next      = proto;
    opcode_next     = opcode;
    typed_next      = typed;
    proto_seen_next = proto_seen;
    opc_seen_next   = opc_seen;
    echo_next       = echo;
    reply_next      = reply;
    syn_next        = syn;
    pos_next        = (pos == efcs_pkg::POS_LIMIT) ? pos : pos + 1'b1;

    if (in_range && pos == efcs_pkg::POS_ETYPE_HI) begin
      etype_next = {frame_byte, 8'h00};
    end else if (in_range && pos == efcs_pkg::POS_ETYPE_LO) begin
      etype_next = {etype[15:8], frame_byte};
      typed_next = 1'b1;
    end

    if (parse && ipv4) begin
      if (pos == efcs_pkg::POS_IP_IHL) begin
        hdr_words_next = frame_byte[3:0];
      end
      if (pos == efcs_pkg::POS_IP_PROTO) begin
        proto_next      = frame_byte;
        proto_seen_next = 1'b1;
      end
      // The transport header lies past byte 33, so the protocol is always
      // registered by the time it is reached.
      if (proto_seen && hdr_words >= efcs_pkg::IHL_MIN) begin
        if (proto == efcs_pkg::PROTO_ICMP && pos == tp) begin
          if (frame_byte == efcs_pkg::ICMP_ECHO_REQ) begin
            echo_next = 1'b1;
          end else if (frame_byte == efcs_pkg::ICMP_ECHO_REP) begin
            reply_next = 1'b1;
          end
        end
        if (proto == efcs_pkg::PROTO_TCP && pos == tp + efcs_pkg::TCP_FLAGS_OFS &&
            frame_byte[efcs_pkg::TCP_SYN_BIT]) begin
          syn_next = 1'b1;
        end
      end
    end else if (parse && arp) begin
      if (pos == efcs_pkg::POS_OPC_HI) begin
        opcode_next = {frame_byte, 8'h00};
      end else if (pos == efcs_pkg::POS_OPC_LO) begin
        opcode_next   = {opcode[15:8], frame_byte};
        opc_seen_next = 1'b1;
      end
    end
  end

  // The record reflects the last byte as well.
  assign ip_ok  = typed_next && etype_next == efcs_pkg::ETYPE_IPV4 && proto_seen_next;
  assign arp_ok = typed_next && etype_next == efcs_pkg::ETYPE_ARP;

  always_comb begin
    rec.size        = (pos_next > MaxFrame) ? MaxFrame : pos_next;
    rec.cls.arp     = arp_ok;
    rec.cls.arp_req = arp_ok && opc_seen_next && opcode_next == efcs_pkg::ARP_OP_REQ;
    rec.cls.arp_rep = arp_ok && opc_seen_next && opcode_next == efcs_pkg::ARP_OP_REP;
    rec.cls.icmp    = ip_ok && proto_next == efcs_pkg::PROTO_ICMP;
    rec.cls.echo    = ip_ok && proto_next == efcs_pkg::PROTO_ICMP && echo_next;
    rec.cls.reply   = ip_ok && proto_next == efcs_pkg::PROTO_ICMP && reply_next;
    rec.cls.udp     = ip_ok && proto_next == efcs_pkg::PROTO_UDP;
    rec.cls.tcp     = ip_ok && proto_next == efcs_pkg::PROTO_TCP;
    rec.cls.syn     = ip_ok && proto_next == efcs_pkg::PROTO_TCP && syn_next;
  end

  assign push = beat && end_of_frame;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos        <= '0;
      etype      <= '0;
      hdr_words  <= '0;
      proto      <= '0;
      opcode     <= '0;
      typed      <= 1'b0;
      proto_seen <= 1'b0;
      opc_seen   <= 1'b0;
      echo       <= 1'b0;
      reply      <= 1'b0;
      syn        <= 1'b0;
    end else if (beat) begin
      pos        <= pos_next;
      etype      <= etype_next;
      hdr_words  <= hdr_words_next;
      proto      <= proto_next;
      opcode     <= opcode_next;
      typed      <= typed_next;
      proto_seen <= proto_seen_next;
      opc_seen   <= opc_seen_next;
      echo       <= echo_next;
      reply      <= reply_next;
      syn        <= syn_next;
    end
  end

endmodule

@@ src/efcs_queue.sv @@
// ----------------------------------------------------------------------------
// efcs_queue
// Short first-in first-out queue of frame records between parser and
// statistics engine.
// ----------------------------------------------------------------------------
module efcs_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  efcs_pkg::frame_rec_t    push_rec,
  input  logic                    pop,
  output efcs_pkg::frame_rec_t    pop_rec,
  output efcs_pkg::queue_status_t status
);

  localparam int PtrW = $clog2(efcs_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(efcs_pkg::QUEUE_DEPTH + 1);

  efcs_pkg::frame_rec_t entries [efcs_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic do_push, do_pop;

  assign status.full  = count == CntW'(efcs_pkg::QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign pop_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(efcs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(efcs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/efcs_stats.sv @@
// ----------------------------------------------------------------------------
// efcs_stats
// Back part: takes one frame record, updates the saturating statistics and
// then sends all thirteen statistics out through an output register.
// ----------------------------------------------------------------------------
module efcs_stats #(
  parameter int COUNTER_WIDTH = efcs_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  efcs_pkg::frame_rec_t                  rec,
  input  efcs_pkg::queue_status_t               qstat,
  output logic                                  pop,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [efcs_pkg::OUT_TDATA_W-1:0]      m_tdata,
  output logic                                  m_tlast
);

  efcs_pkg::back_state_t state, state_next;
  efcs_pkg::stat_id_t    idx, idx_next;

  logic [COUNTER_WIDTH-1:0]   counters [efcs_pkg::NUM_COUNTERS];
  logic [efcs_pkg::STAT_W-1:0] byte_total;
  logic [efcs_pkg::POS_W-1:0]  size_min, size_max;

  logic [efcs_pkg::NUM_COUNTERS-1:0] bump;
  logic [efcs_pkg::STAT_W:0]         total_sum;
  logic                              load;
  logic [efcs_pkg::STAT_W-1:0]       sel_value;
  logic [efcs_pkg::STAT_ID_W-1:0]    cnt_sel;

  logic [efcs_pkg::STAT_ID_W-1:0] out_id;
  logic [efcs_pkg::STAT_W-1:0]    out_value;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    pop        = 1'b0;
    load       = 1'b0;
    unique case (state)
      efcs_pkg::BK_IDLE: begin
        if (!qstat.empty) begin
          pop        = 1'b1;
          idx_next   = efcs_pkg::STAT_FRAMES;
          state_next = efcs_pkg::BK_EMIT;
        end
      end
      efcs_pkg::BK_EMIT: begin
        if (!m_tvalid || m_tready) begin
          load = 1'b1;
          if (idx == efcs_pkg::STAT_SYN) begin
            state_next = efcs_pkg::BK_IDLE;
          end else begin
            idx_next = efcs_pkg::stat_id_t'(idx + 1'b1);
          end
        end
      end
      default: state_next = efcs_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efcs_pkg::BK_IDLE;
      idx   <= efcs_pkg::STAT_FRAMES;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  assign bump      = {rec.cls, 1'b1};
  assign total_sum = {1'b0, byte_total} + (efcs_pkg::STAT_W + 1)'(rec.size);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < efcs_pkg::NUM_COUNTERS; i++) begin
        counters[i] <= '0;
      end
      byte_total <= '0;
      size_min   <= '1;
      size_max   <= '0;
    end else if (pop) begin
      for (int i = 0; i < efcs_pkg::NUM_COUNTERS; i++) begin
        if (bump[i] && counters[i] != {COUNTER_WIDTH{1'b1}}) begin
          counters[i] <= counters[i] + 1'b1;
        end
      end
      if (rec.size < size_min) begin
        size_min <= rec.size;
      end
      if (rec.size > size_max) begin
        size_max <= rec.size;
      end
      byte_total <= total_sum[efcs_pkg::STAT_W] ? '1 : total_sum[efcs_pkg::STAT_W-1:0];
    end
  end

  // Class counters follow the four frame statistics in stat_id order, and
  // counter 0 is the frame counter, so the offset is the byte total's id.
  assign cnt_sel = idx - efcs_pkg::STAT_BYTES;

  always_comb begin
    unique case (idx)
      efcs_pkg::STAT_FRAMES: sel_value = efcs_pkg::STAT_W'(counters[0]);
      efcs_pkg::STAT_MIN:    sel_value = efcs_pkg::STAT_W'(size_min);
      efcs_pkg::STAT_MAX:    sel_value = efcs_pkg::STAT_W'(size_max);
      efcs_pkg::STAT_BYTES:  sel_value = byte_total;
      default: sel_value = efcs_pkg::STAT_W'(counters[cnt_sel[efcs_pkg::CNT_IDX_W-1:0]]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_id    <= idx;
      out_value <= sel_value;
      m_tlast   <= idx == efcs_pkg::STAT_SYN;
    end
  end

  assign m_tdata = {{(efcs_pkg::OUT_TDATA_W - efcs_pkg::STAT_W - efcs_pkg::STAT_ID_W){1'b0}},
                    out_value, out_id};

endmodule

@@ src/efcs_checker.sv @@
// ----------------------------------------------------------------------------
// efcs_checker
// Port-level checks on the statistics stream of the frame class statistics
// block.
// ----------------------------------------------------------------------------
module efcs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [efcs_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                             m_tlast
);

  // Statistic expected on the next output beat.
  logic [efcs_pkg::STAT_ID_W-1:0] exp_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_id <= efcs_pkg::STAT_FRAMES;
    end else if (m_tvalid && m_tready) begin
      exp_id <= m_tlast ? efcs_pkg::STAT_FRAMES : exp_id + 1'b1;
    end
  end

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat withdrawn while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_id_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[efcs_pkg::STAT_ID_W-1:0] == exp_id)
    else $error("statistics out of order");

  a_last_on_syn: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[efcs_pkg::STAT_ID_W-1:0] ==
                              efcs_pkg::STAT_ID_W'(efcs_pkg::STAT_SYN))))
    else $error("tlast not on the final statistic");

endmodule

bind ethernet_frame_class_statistics efcs_checker u_efcs_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);
